[hw/rtl/psw_pkg.sv]
// Shared types and constants for the strip-weight projector.
// No dependencies; used by every file under hw/rtl except psw_if.
package psw_pkg;

  localparam int unsigned MAX_IMAGE_DIM = 512;
  localparam int unsigned MAX_BINS      = 1024;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // numerator and divisor widths of the weight divider
  localparam int unsigned NUM_W = 47;
  localparam int unsigned DEN_W = 32;
  // quotient bits worked out one per stage
  localparam int unsigned Q_BITS = 17;
  // divider depth: overflow stage plus one stage per quotient bit
  localparam int unsigned DIV_LAT = Q_BITS + 1;
  // edge setup stages in front of the divider
  localparam int unsigned EDGE_LAT = 2;
  localparam int unsigned SB_DEPTH = EDGE_LAT + DIV_LAT;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_BIN_COUNT    = 2'd2
  } cfg_idx_t;

  // geometry result handed to the edge stages
  typedef struct packed {
    logic               vld;
    logic               in_range;
    logic [10:0]        bin;
    logic [15:0]        a;
    logic [15:0]        b;
    logic signed [15:0] r;
  } geom_t;

  // divider operands of one edge
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             zero;
  } div_in_t;

endpackage

[hw/rtl/psw_if.sv]
// Handshake channels of the strip-weight projector: pixel in, weights out.
// Standalone; no package needed.
interface psw_pix_if;
  logic               valid;
  logic               ready;
  logic [8:0]         pixel_row;
  logic [8:0]         pixel_col;
  logic signed [15:0] angle_cos;
  logic signed [15:0] angle_sin;

  modport source(output valid, pixel_row, pixel_col, angle_cos, angle_sin, input ready);
  modport sink(input valid, pixel_row, pixel_col, angle_cos, angle_sin, output ready);
endinterface

interface psw_wgt_if;
  logic               valid;
  logic               ready;
  logic               in_range;
  logic signed [10:0] bin_index;
  logic [16:0]        weight_low;
  logic [16:0]        weight_mid;
  logic [16:0]        weight_high;

  modport source(output valid, in_range, bin_index, weight_low, weight_mid, weight_high,
                 input ready);
  modport sink(input valid, in_range, bin_index, weight_low, weight_mid, weight_high,
               output ready);
endinterface

[hw/rtl/psw_geom.sv]
// Projection of the pixel centre, rounding to a bin and window check (3 stages).
// Depends on psw_pkg.
module psw_geom (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [9:0]         image_width,
  input  logic [9:0]         image_height,
  input  logic [10:0]        bin_count,
  input  logic               pvld,
  input  logic [8:0]         pixel_row,
  input  logic [8:0]         pixel_col,
  input  logic signed [15:0] angle_cos,
  input  logic signed [15:0] angle_sin,
  output psw_pkg::geom_t     geo
);

  logic [8:0]         half_w;
  logic [8:0]         half_h;
  logic signed [10:0] x;
  logic signed [10:0] y;
  logic signed [26:0] px_full;
  logic signed [26:0] py_full;
  logic [15:0]        aco;
  logic [15:0]        asi;

  logic               vld1;
  logic signed [26:0] px1;
  logic signed [26:0] py1;
  logic [15:0]        a1;
  logic [15:0]        b1;

  logic               vld2;
  logic signed [27:0] xx2;
  logic [15:0]        a2;
  logic [15:0]        b2;

  logic signed [27:0] xr;
  logic signed [13:0] ix;
  logic signed [14:0] e;
  logic signed [14:0] pos;
  logic signed [14:0] pos_max;

  assign half_w = image_width[9:1];
  assign half_h = image_height[9:1];

  assign x = $signed({2'b0, pixel_col}) - $signed({2'b0, half_w});
  assign y = $signed({2'b0, half_h}) - $signed({2'b0, pixel_row});
  assign px_full = x * angle_cos;
  assign py_full = y * angle_sin;
  assign aco = angle_cos[15] ? 16'(-angle_cos) : angle_cos;
  assign asi = angle_sin[15] ? 16'(-angle_sin) : angle_sin;

  // stage 3: round to nearest bin, residue in Q15
  assign xr      = xx2 + 28'sd8192;
  assign ix      = xr[27:14];
  assign e       = $signed({1'b0, xr[13:0]}) - 15'sd8192;
  assign pos     = $signed({ix[13], ix}) + $signed({6'b0, half_w});
  assign pos_max = $signed({5'b0, image_width}) - 15'sd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      geo.vld <= 1'b0;
    end else if (en) begin
      vld1 <= pvld;
      vld2 <= vld1;
      geo.vld      <= vld2;
      geo.in_range <= (pos >= 15'sd1) && (pos <= pos_max);
      geo.bin      <= ix[10:0] + {1'b0, bin_count[10:1]} - 11'd1;
      geo.a        <= a2;
      geo.b        <= b2;
      geo.r        <= {e, 1'b0};
    end
  end

  // stage 1: the two products and the footprint half-widths
  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= px_full;
      py1 <= py_full;
      a1  <= (asi > aco) ? asi : aco;
      b1  <= (asi > aco) ? aco : asi;
    end
  end

  // stage 2: projected centre, Q14
  always_ff @(posedge clk) begin
    if (en) begin
      xx2 <= 28'(px1) + 28'(py1);
      a2  <= a1;
      b2  <= b1;
    end
  end

endmodule

[hw/rtl/psw_edge.sv]
// Overhang of the footprint beyond one bin edge and the divider operands (2 stages).
// Depends on psw_pkg.
module psw_edge (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        a,
  input  logic [15:0]        b,
  input  logic signed [15:0] rs,
  output psw_pkg::div_in_t   dvin
);

  logic signed [18:0] rs_x;
  logic signed [18:0] dl;
  logic signed [18:0] dq;
  logic signed [18:0] ln;

  logic        lin1;
  logic        quad1;
  logic [16:0] lnum1;
  logic [33:0] sq1;
  logic [31:0] ab1;
  logic [15:0] a1;

  logic [psw_pkg::NUM_W-1:0] num;
  logic [psw_pkg::DEN_W-1:0] den;

  assign rs_x = {{3{rs[15]}}, rs};
  assign dl = $signed({3'b0, a}) - $signed({3'b0, b}) - 19'sd16384 + rs_x;
  assign dq = $signed({3'b0, a}) + $signed({3'b0, b}) - 19'sd16384 + rs_x;
  assign ln = $signed({3'b0, a}) - 19'sd16384 + rs_x;

  // stage 1: pick linear or quadratic part of the trapezoid
  always_ff @(posedge clk) begin
    if (en) begin
      lin1  <= dl > 19'sd0;
      quad1 <= (dl <= 19'sd0) && (dq > 19'sd0);
      lnum1 <= ln[16:0];
      sq1   <= dq[16:0] * dq[16:0];
      ab1   <= a * b;
      a1    <= a;
    end
  end

  always_comb begin
    num = '0;
    den = {16'b0, a1};
    if (lin1) begin
      num = {15'b0, lnum1, 15'b0};
    end else if (quad1) begin
      num = {sq1, 13'b0};
      den = ab1;
    end
  end

  // stage 2: numerator with half the divisor added for round to nearest
  always_ff @(posedge clk) begin
    if (en) begin
      dvin.num  <= num + psw_pkg::NUM_W'(den >> 1);
      dvin.den  <= den;
      dvin.zero <= !(lin1 || quad1) || (den == '0);
    end
  end

endmodule

[hw/rtl/psw_div.sv]
// Pipelined restoring divider, one quotient bit per stage, saturating at one in Q1.16.
// Depends on psw_pkg.
module psw_div (
  input  logic             clk,
  input  logic             en,
  input  psw_pkg::div_in_t din,
  output logic [16:0]      quo
);

  localparam int unsigned LAST = psw_pkg::DIV_LAT - 1;
  localparam int unsigned REM_W = psw_pkg::DEN_W + psw_pkg::Q_BITS + 1;

  logic [REM_W-1:0]          rem   [0:LAST];
  logic [psw_pkg::DEN_W-1:0] den_s [0:LAST];
  logic [16:0]               q_s   [0:LAST];
  logic [LAST:0]             ovf_s;
  logic [LAST:0]             zero_s;
  logic [REM_W:0]            trial [1:LAST];

  always_comb begin
    for (int s = 1; s <= LAST; s++) begin
      trial[s] = {1'b0, rem[s-1]} - ((REM_W+1)'(den_s[s-1]) << (LAST - s));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // quotient of two to the seventeenth or more saturates anyway
      rem[0]    <= REM_W'(din.num);
      den_s[0]  <= din.den;
      q_s[0]    <= '0;
      ovf_s[0]  <= REM_W'(din.num) >= (REM_W'(din.den) << psw_pkg::Q_BITS);
      zero_s[0] <= din.zero;
      for (int s = 1; s <= LAST; s++) begin
        rem[s]    <= trial[s][REM_W] ? rem[s-1] : trial[s][REM_W-1:0];
        q_s[s]    <= {q_s[s-1][15:0], !trial[s][REM_W]};
        den_s[s]  <= den_s[s-1];
        ovf_s[s]  <= ovf_s[s-1];
        zero_s[s] <= zero_s[s-1];
      end
    end
  end

  always_comb begin
    if (zero_s[LAST]) begin
      quo = '0;
    end else if (ovf_s[LAST] || (q_s[LAST] > psw_pkg::ONE_Q16)) begin
      quo = psw_pkg::ONE_Q16;
    end else begin
      quo = q_s[LAST];
    end
  end

endmodule

[hw/rtl/projector_strip_weights.sv]
// Top level of the strip-area projection weight engine.
// Depends on psw_pkg, psw_if, psw_geom, psw_edge and psw_div.
//
// Takes one pixel/angle transaction per clock and returns one weight transaction per
// pixel, in order. Throughput is one per cycle, no gaps, unless the output stalls;
// a pixel passes the geometry stages, the edge setup stages, the weight dividers
// (an overflow stage plus the quotient-bit stages) and an output register. A
// stall on the output holds the whole pipeline; nothing is dropped. Registers are
// written through cfg_we/cfg_index/cfg_data and should change only while idle.
module projector_strip_weights (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [10:0]     cfg_data,
  psw_pix_if.sink         pix,
  psw_wgt_if.source       wgt
);

  localparam int unsigned SBL = psw_pkg::SB_DEPTH - 1;

  logic [9:0]  image_width;
  logic [9:0]  image_height;
  logic [10:0] bin_count;

  logic en;
  psw_pkg::geom_t   geo;
  psw_pkg::div_in_t dv_lo;
  psw_pkg::div_in_t dv_hi;
  logic signed [15:0] r_neg;
  logic [16:0] wl;
  logic [16:0] wh;
  logic [17:0] w_sum;
  logic [16:0] wm;

  logic [SBL:0] sb_vld;
  logic [SBL:0] sb_rng;
  logic [10:0]  sb_bin [0:SBL];

  logic               ov;
  logic               o_rng;
  logic [10:0]        o_bin;
  logic [16:0]        o_wl;
  logic [16:0]        o_wm;
  logic [16:0]        o_wh;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 10'd128;
      image_height <= 10'd128;
      bin_count    <= 11'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        psw_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[9:0];
        psw_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data[9:0];
        psw_pkg::CFG_BIN_COUNT:    bin_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en        = !ov || wgt.ready;
  assign pix.ready = en;

  psw_geom u_geom (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .image_width  (image_width),
    .image_height (image_height),
    .bin_count    (bin_count),
    .pvld         (pix.valid),
    .pixel_row    (pix.pixel_row),
    .pixel_col    (pix.pixel_col),
    .angle_cos    (pix.angle_cos),
    .angle_sin    (pix.angle_sin),
    .geo          (geo)
  );

  // lower edge sees the residue mirrored
  assign r_neg = -geo.r;

  psw_edge u_edge_lo (
    .clk  (clk),
    .en   (en),
    .a    (geo.a),
    .b    (geo.b),
    .rs   (r_neg),
    .dvin (dv_lo)
  );

  psw_edge u_edge_hi (
    .clk  (clk),
    .en   (en),
    .a    (geo.a),
    .b    (geo.b),
    .rs   (geo.r),
    .dvin (dv_hi)
  );

  psw_div u_div_lo (
    .clk (clk),
    .en  (en),
    .din (dv_lo),
    .quo (wl)
  );

  psw_div u_div_hi (
    .clk (clk),
    .en  (en),
    .din (dv_hi),
    .quo (wh)
  );

  // sideband travels alongside the edge and divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      sb_vld <= '0;
    end else if (en) begin
      sb_vld <= {sb_vld[SBL-1:0], geo.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_rng    <= {sb_rng[SBL-1:0], geo.in_range};
      sb_bin[0] <= geo.bin;
      for (int i = 1; i <= SBL; i++) begin
        sb_bin[i] <= sb_bin[i-1];
      end
    end
  end

  assign w_sum = {1'b0, wl} + {1'b0, wh};
  assign wm = (w_sum >= {1'b0, psw_pkg::ONE_Q16}) ? 17'd0
                                                  : 17'({1'b0, psw_pkg::ONE_Q16} - w_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= sb_vld[SBL];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sb_rng[SBL]) begin
        o_rng <= 1'b1;
        o_bin <= sb_bin[SBL];
        o_wl  <= wl;
        o_wm  <= wm;
        o_wh  <= wh;
      end else begin
        o_rng <= 1'b0;
        o_bin <= '0;
        o_wl  <= '0;
        o_wm  <= '0;
        o_wh  <= '0;
      end
    end
  end

  assign wgt.valid       = ov;
  assign wgt.in_range    = o_rng;
  assign wgt.bin_index   = o_bin;
  assign wgt.weight_low  = o_wl;
  assign wgt.weight_mid  = o_wm;
  assign wgt.weight_high = o_wh;

endmodule

[dv/testbench.sv]
// Self-checking bench for projector_strip_weights: directed table, then random pixels.
// Depends on psw_pkg, psw_if and the RTL top level.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic        in_range;
    logic [10:0] bin_index;
    logic [16:0] weight_low;
    logic [16:0] weight_mid;
    logic [16:0] weight_high;
  } weights_t;

  typedef struct packed {
    logic [8:0]  row;
    logic [8:0]  col;
    logic [15:0] cs;
    logic [15:0] sn;
    logic        has_gold;
    weights_t    gold;
  } pix_row_t;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = psw_pkg::CFG_IMAGE_WIDTH;
  logic [10:0] cfg_data = '0;

  psw_pix_if pix ();
  psw_wgt_if wgt ();

  projector_strip_weights DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pix(pix), .wgt(wgt)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // model copy of the registers
  longint width_r = 128, height_r = 128, bins_r = 128;
  weights_t expected_weights[$];
  int mismatches = 0, matched = 0, sent = 0, idle_cycles = 0;
  int src_idle_pct = 0, snk_stall_pct = 0;

  function automatic longint ratio_q16(longint num, longint den);
    longint q;
    if (num <= 0 || den <= 0) return 0;
    q = (num + den / 2) / den;
    return q > 65536 ? 65536 : q;
  endfunction

  function automatic longint overhang_weight(longint dl, longint dq, longint a, longint b);
    if (dl > 0) return a > 0 ? ratio_q16((b + dl) * 32768, a) : 0;
    if (dq > 0) return (a > 0 && b > 0) ? ratio_q16(dq * dq * 8192, a * b) : 0;
    return 0;
  endfunction

  function automatic weights_t strip_weights(logic [8:0] row, logic [8:0] col,
                                             logic signed [15:0] cs, logic signed [15:0] sn);
    weights_t w;
    longint hw, x, y, xx, dx, ix, pos, ac, as_, a, b, le, he, wl, wh, wm;
    hw = width_r / 2;
    x = longint'(col) - hw;
    y = height_r / 2 - longint'(row);
    xx = x * longint'(cs) + y * longint'(sn);
    dx = 2 * xx;
    ix = (xx + 8192) >>> 14;
    pos = ix + hw;
    ac = cs < 0 ? -longint'(cs) : longint'(cs);
    as_ = sn < 0 ? -longint'(sn) : longint'(sn);
    a = as_ > ac ? as_ : ac;
    b = as_ > ac ? ac : as_;
    w = '0;
    if (pos < 1 || pos > width_r - 2) return w;
    le = ix * 32768 - 16384;
    he = ix * 32768 + 16384;
    wl = overhang_weight(le - (dx - (a - b)), le - (dx - (a + b)), a, b);
    wh = overhang_weight(dx + (a - b) - he, dx + (a + b) - he, a, b);
    wm = 65536 - wl - wh;
    if (wm < 0) wm = 0;
    w.in_range = 1'b1;
    w.bin_index = 11'(ix + bins_r / 2 - 1);
    w.weight_low = 17'(wl);
    w.weight_mid = 17'(wm);
    w.weight_high = 17'(wh);
    return w;
  endfunction

  // receiver: stalls at random, checks against the oldest expectation
  always @(posedge clk) begin
    weights_t got, want;
    if (rst) begin
      wgt.ready <= 1'b0;
    end else begin
      wgt.ready <= ($urandom_range(99) >= snk_stall_pct);
      if (wgt.valid && wgt.ready) begin
        got = {wgt.in_range, wgt.bin_index, wgt.weight_low, wgt.weight_mid, wgt.weight_high};
        if (expected_weights.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction %h", got);
        end else begin
          want = expected_weights.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp rng %b bin %0d lo %0d mid %0d hi %0d",
                        " / got rng %b bin %0d lo %0d mid %0d hi %0d"},
                       want.in_range, $signed(want.bin_index), want.weight_low, want.weight_mid,
                       want.weight_high, got.in_range, $signed(got.bin_index), got.weight_low,
                       got.weight_mid, got.weight_high);
          end else matched++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (wgt.valid && wgt.ready)) idle_cycles <= 0;
    else if (!rst && (pix.valid || expected_weights.size() != 0)) idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog expired");
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_pixel(pix_row_t p);
    weights_t w;
    while ($urandom_range(99) < src_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel_row <= p.row;
    pix.pixel_col <= p.col;
    pix.angle_cos <= p.cs;
    pix.angle_sin <= p.sn;
    w = strip_weights(p.row, p.col, p.cs, p.sn);
    if (p.has_gold && p.gold !== w) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees with predictor: %h vs %h", p.gold, w);
    end
    do @(posedge clk); while (!pix.ready);
    expected_weights.push_back(w);
    sent++;
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    while (expected_weights.size() != 0) @(posedge clk);
    repeat (psw_pkg::SB_DEPTH + 10) @(posedge clk);
  endtask

  task automatic write_reg(psw_pkg::cfg_idx_t idx, logic [10:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      psw_pkg::CFG_IMAGE_WIDTH: width_r = val & 11'h3ff;
      psw_pkg::CFG_IMAGE_HEIGHT: height_r = val & 11'h3ff;
      default: bins_r = val;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_trig();
    case ($urandom_range(5))
      0: return 16'(16384);
      1: return 16'(-16384);
      2: return 16'h0000;
      3: return 16'($urandom);
      default: return 16'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  pix_row_t table_rows[$];

  initial begin
    pix_row_t p;
    int unsigned cfg_sel;
    pix.valid = 1'b0;
    pix.pixel_row = '0;
    pix.pixel_col = '0;
    pix.angle_cos = '0;
    pix.angle_sin = '0;
    wgt.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: centre pixel at 0 deg -> bin 63, full middle weight
    table_rows.push_back('{9'd64, 9'd64, 16'sd16384, 16'sd0, 1'b1,
                           '{1'b1, 11'd63, 17'd0, 17'h10000, 17'd0}});
    // zero angle vector at centre
    table_rows.push_back('{9'd64, 9'd64, 16'sd0, 16'sd0, 1'b1,
                           '{1'b1, 11'd63, 17'd0, 17'h10000, 17'd0}});
    // column 0 lands at pos 0: out of window
    table_rows.push_back('{9'd0, 9'd0, 16'sd16384, 16'sd0, 1'b1, '0});
    // most negative cos and sin: projects onto the centre, corners spill both ways
    table_rows.push_back('{9'd511, 9'd511, 16'h8000, 16'h8000, 1'b1,
                           '{1'b1, 11'd63, 17'd18432, 17'd28672, 17'd18432}});
    table_rows.push_back('{9'd64, 9'd127, 16'sd16384, 16'sd0, 1'b1, '0});
    table_rows.push_back('{9'd64, 9'd126, 16'sd16384, 16'sd0, 1'b0, '0});
    table_rows.push_back('{9'd64, 9'd1, 16'sd16384, 16'sd0, 1'b0, '0});
    table_rows.push_back('{9'd10, 9'd70, 16'sd11585, 16'sd11585, 1'b0, '0});
    table_rows.push_back('{9'd100, 9'd30, -16'sd11585, 16'sd11585, 1'b0, '0});
    table_rows.push_back('{9'd64, 9'd64, 16'h7fff, 16'h7fff, 1'b0, '0});
    table_rows.push_back('{9'd60, 9'd66, 16'sd15137, -16'sd6270, 1'b0, '0});
    table_rows.push_back('{9'd64, 9'd64, 16'sd0, -16'sd16384, 1'b0, '0});
    table_rows.push_back('{9'd3, 9'd64, 16'sd0, 16'sd16384, 1'b0, '0});
    table_rows.push_back('{9'd64, 9'd80, 16'sd8192, 16'sd0, 1'b0, '0});
    foreach (table_rows[i]) send_pixel(table_rows[i]);
    drain();

    // random phases, register settings cycled through extremes
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0; snk_stall_pct = 0; end
        1: begin src_idle_pct = 86; snk_stall_pct = 0; end
        2: begin src_idle_pct = 0; snk_stall_pct = 86; end
        default: begin src_idle_pct = 14; snk_stall_pct = 14; end
      endcase
      cfg_sel = ph % 6;
      case (cfg_sel)
        0: begin write_reg(psw_pkg::CFG_IMAGE_WIDTH, 11'd2);
                 write_reg(psw_pkg::CFG_IMAGE_HEIGHT, 11'd2);
                 write_reg(psw_pkg::CFG_BIN_COUNT, 11'd2); end
        1: begin write_reg(psw_pkg::CFG_IMAGE_WIDTH, 11'd512);
                 write_reg(psw_pkg::CFG_IMAGE_HEIGHT, 11'd512);
                 write_reg(psw_pkg::CFG_BIN_COUNT, 11'd1024); end
        2: begin write_reg(psw_pkg::CFG_IMAGE_WIDTH, 11'($urandom_range(1023)));
                 write_reg(psw_pkg::CFG_IMAGE_HEIGHT, 11'($urandom_range(1023)));
                 write_reg(psw_pkg::CFG_BIN_COUNT, 11'($urandom_range(2047))); end
        3: begin write_reg(psw_pkg::CFG_IMAGE_WIDTH, 11'd1023);
                 write_reg(psw_pkg::CFG_IMAGE_HEIGHT, 11'd1023);
                 write_reg(psw_pkg::CFG_BIN_COUNT, 11'd2047); end
        4: begin write_reg(psw_pkg::CFG_IMAGE_WIDTH, 11'd0);
                 write_reg(psw_pkg::CFG_BIN_COUNT, 11'd0); end
        default: begin write_reg(psw_pkg::CFG_IMAGE_WIDTH, 11'd128);
                 write_reg(psw_pkg::CFG_IMAGE_HEIGHT, 11'd128);
                 write_reg(psw_pkg::CFG_BIN_COUNT, 11'd128); end
      endcase
      for (int k = 0; k < 100; k++) begin
        p = '0;
        // mostly pixels within the current image, some anywhere
        if ($urandom_range(9) < 8 && width_r > 0 && height_r > 0) begin
          p.row = 9'($urandom_range((height_r > 512 ? 512 : height_r) - 1));
          p.col = 9'($urandom_range((width_r > 512 ? 512 : width_r) - 1));
        end else begin
          p.row = 9'($urandom);
          p.col = 9'($urandom);
        end
        p.cs = rand_trig();
        p.sn = rand_trig();
        send_pixel(p);
      end
      drain();
    end

    $display("%0d pixel transactions sent, %0d weight transactions matched", sent, matched);
    $display("covered register extremes and four handshake idling phases");
    if (mismatches == 0 && expected_weights.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end
endmodule
